FILE: hw/rtl/colac_pkg.sv
// Shared types, constants and saturation helpers for the angle controller.
// No dependencies; every other file in hw/rtl imports this package.
package colac_pkg;

  localparam int WORD_W       = 32;
  localparam int FRAC_DEFAULT = 16;
  localparam int ACC_W        = WORD_W + 3;
  localparam int CFG_IDX_W    = 4;
  localparam int OP_CNT_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FB_ONE = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FB_TWO = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FF_ZRO = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FF_ONE = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FF_TWO = 4'd7;

  localparam logic MODE_CASCADE  = 1'b0;
  localparam logic MODE_LEADLAG  = 1'b1;

  localparam logic [OP_CNT_W-1:0] OP_FB_ONE = 3'd0;
  localparam logic [OP_CNT_W-1:0] OP_FB_TWO = 3'd1;
  localparam logic [OP_CNT_W-1:0] OP_FF_ZRO = 3'd2;
  localparam logic [OP_CNT_W-1:0] OP_FF_ONE = 3'd3;
  localparam logic [OP_CNT_W-1:0] OP_FF_TWO = 3'd4;
  localparam logic [OP_CNT_W-1:0] LEADLAG_OPS = 3'd5;
  localparam logic [OP_CNT_W-1:0] CASCADE_OPS = 3'd1;

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef struct packed {
    logic signed [WORD_W-1:0] angle_target;
    logic signed [WORD_W-1:0] angle_measured;
    logic signed [WORD_W-1:0] angle_rate;
  } in_beat_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] accel_command;
    logic                     saturated;
  } out_beat_t;

  typedef struct packed {
    logic                     start;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic                     clip;
    logic signed [WORD_W-1:0] q;
  } mul_rsp_t;

  typedef struct packed {
    logic                     clip;
    logic signed [WORD_W-1:0] value;
  } sat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_ISSUE,
    ST_DRAIN,
    ST_SUB,
    ST_FINISH
  } state_t;

  function automatic sat_t sat_one(input logic signed [WORD_W:0] x);
    sat_t r;
    r.clip  = x[WORD_W] != x[WORD_W-1];
    r.value = r.clip ? (x[WORD_W] ? WORD_MIN : WORD_MAX) : x[WORD_W-1:0];
    return r;
  endfunction

  function automatic sat_t sat_acc(input logic signed [ACC_W-1:0] x);
    sat_t r;
    r.clip  = !((&x[ACC_W-1:WORD_W-1]) || !(|x[ACC_W-1:WORD_W-1]));
    r.value = r.clip ? (x[ACC_W-1] ? WORD_MIN : WORD_MAX) : x[WORD_W-1:0];
    return r;
  endfunction

endpackage

FILE: hw/rtl/colac_mul.sv
// Shared two-stage fixed-point multiplier: product register, then floor
// shift and saturation to one word. Depends on colac_pkg.
module colac_mul #(
  parameter int FRAC_BITS = colac_pkg::FRAC_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  colac_pkg::mul_req_t req,
  output colac_pkg::mul_rsp_t rsp
);
  import colac_pkg::*;

  logic signed [2*WORD_W-1:0] prod;
  logic signed [2*WORD_W-1:0] shifted;
  logic                       prod_valid;
  logic                       fits;

  assign shifted = prod >>> FRAC_BITS;
  assign fits    = (&shifted[2*WORD_W-1:WORD_W-1]) || !(|shifted[2*WORD_W-1:WORD_W-1]);

  always_ff @(posedge clk) begin
    prod     <= req.a * req.b;
    rsp.clip <= !fits;
    rsp.q    <= fits ? shifted[WORD_W-1:0]
                     : (shifted[2*WORD_W-1] ? WORD_MIN : WORD_MAX);
    if (rst) begin
      prod_valid <= 1'b0;
      rsp.done   <= 1'b0;
    end else begin
      prod_valid <= req.start;
      rsp.done   <= prod_valid;
    end
  end

endmodule

FILE: hw/rtl/cascade_or_leadlag_angle_controller_unit.sv
// Angle controller top level: cascade or lead-lag law on one shared multiplier.
// Depends on colac_pkg and colac_mul.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one beat carries the commanded
//     angle, measured angle and angular rate, all signed Q16.16.
//   out channel (out_valid/out_ready/out_data): one beat per input beat with
//     the saturated acceleration command and a clip flag.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//     indexes 0..7 write mode, gains and coefficients, others are dropped.
//     Write only while the block is idle.
// Timing: in lead-lag mode the five products are issued back to back; in cascade
//   mode the two products are dependent, the second issued after the first drains.
//   in_ready returns together with out_valid, so a new beat is not taken before
//   the last one is finished; every product passes the two-stage multiplier.
// Reset: mode goes to lead-lag, all gains and history to zero, no beat held.
// A stalled receiver holds the result in the output register; a new input
//   beat is still taken and worked on, and its result waits until it drains.
module cascade_or_leadlag_angle_controller_unit #(
  parameter int FRAC_BITS = colac_pkg::FRAC_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  colac_pkg::in_beat_t                   in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output colac_pkg::out_beat_t                  out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [colac_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic signed [colac_pkg::WORD_W-1:0]   cfg_data
);
  import colac_pkg::*;

  state_t state;
  state_t state_next;

  logic                     mode;
  logic signed [WORD_W-1:0] outer_gain;
  logic signed [WORD_W-1:0] inner_gain;
  logic signed [WORD_W-1:0] fb_one;
  logic signed [WORD_W-1:0] fb_two;
  logic signed [WORD_W-1:0] ff_zro;
  logic signed [WORD_W-1:0] ff_one;
  logic signed [WORD_W-1:0] ff_two;

  in_beat_t                 sample;
  logic signed [WORD_W-1:0] err;
  logic signed [WORD_W-1:0] sub_val;
  logic signed [ACC_W-1:0]  acc;
  logic                     flag;
  logic [OP_CNT_W-1:0]      issue_cnt;
  logic [OP_CNT_W-1:0]      got_cnt;
  logic [OP_CNT_W-1:0]      n_ops;
  logic                     phase;

  logic signed [WORD_W-1:0] error_prev;
  logic signed [WORD_W-1:0] error_prev2;
  logic signed [WORD_W-1:0] output_prev;
  logic signed [WORD_W-1:0] output_prev2;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  sat_t     diff_sat;
  sat_t     sub_sat;
  sat_t     acc_sat;
  logic     finish_fire;

  colac_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  assign cfg_ready = 1'b1;
  assign n_ops     = (mode == MODE_LEADLAG) ? LEADLAG_OPS : CASCADE_OPS;
  assign diff_sat  = sat_one({sample.angle_target[WORD_W-1], sample.angle_target}
                           - {sample.angle_measured[WORD_W-1], sample.angle_measured});
  assign sub_sat   = sat_one({acc[WORD_W-1], acc[WORD_W-1:0]}
                           - {sample.angle_rate[WORD_W-1], sample.angle_rate});
  assign acc_sat   = sat_acc(acc);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_ISSUE;
      ST_ISSUE:  if (issue_cnt == n_ops - 3'd1) state_next = ST_DRAIN;
      ST_DRAIN: begin
        if (got_cnt == n_ops) begin
          state_next = (mode == MODE_CASCADE && !phase) ? ST_SUB : ST_FINISH;
        end
      end
      ST_SUB:    state_next = ST_ISSUE;
      ST_FINISH: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = state == ST_IDLE;
    finish_fire   = state == ST_FINISH && (!out_valid || out_ready);
    mul_req.start = state == ST_ISSUE;
    mul_req.a     = '0;
    mul_req.b     = '0;
    if (mode == MODE_CASCADE) begin
      mul_req.a = phase ? sub_val : err;
      mul_req.b = phase ? inner_gain : outer_gain;
    end else begin
      case (issue_cnt)
        OP_FB_ONE: begin mul_req.a = fb_one; mul_req.b = output_prev;  end
        OP_FB_TWO: begin mul_req.a = fb_two; mul_req.b = output_prev2; end
        OP_FF_ZRO: begin mul_req.a = ff_zro; mul_req.b = err;          end
        OP_FF_ONE: begin mul_req.a = ff_one; mul_req.b = error_prev;   end
        OP_FF_TWO: begin mul_req.a = ff_two; mul_req.b = error_prev2;  end
        default:   begin mul_req.a = '0;     mul_req.b = '0;           end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      issue_cnt <= '0;
      got_cnt   <= '0;
      phase     <= 1'b0;
      flag      <= 1'b0;
    end else begin
      state <= state_next;
      if (finish_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (mul_rsp.done) begin
        got_cnt <= got_cnt + 3'd1;
        flag    <= flag | mul_rsp.clip;
      end
      case (state)
        ST_DIFF: begin
          issue_cnt <= '0;
          got_cnt   <= '0;
          phase     <= 1'b0;
          flag      <= diff_sat.clip;
        end
        ST_ISSUE: issue_cnt <= issue_cnt + 3'd1;
        ST_SUB: begin
          issue_cnt <= '0;
          got_cnt   <= '0;
          phase     <= 1'b1;
          flag      <= flag | sub_sat.clip;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_LEADLAG;
      outer_gain   <= '0;
      inner_gain   <= '0;
      fb_one       <= '0;
      fb_two       <= '0;
      ff_zro       <= '0;
      ff_one       <= '0;
      ff_two       <= '0;
      error_prev   <= '0;
      error_prev2  <= '0;
      output_prev  <= '0;
      output_prev2 <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:   mode       <= cfg_data[0];
          REG_OUTER:  outer_gain <= cfg_data;
          REG_INNER:  inner_gain <= cfg_data;
          REG_FB_ONE: fb_one     <= cfg_data;
          REG_FB_TWO: fb_two     <= cfg_data;
          REG_FF_ZRO: ff_zro     <= cfg_data;
          REG_FF_ONE: ff_one     <= cfg_data;
          REG_FF_TWO: ff_two     <= cfg_data;
          default: ;
        endcase
      end
      if (finish_fire && mode == MODE_LEADLAG) begin
        output_prev2 <= output_prev;
        output_prev  <= acc_sat.value;
        error_prev2  <= error_prev;
        error_prev   <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample <= in_data;
    end
    if (mul_rsp.done) begin
      acc <= acc + {{(ACC_W-WORD_W){mul_rsp.q[WORD_W-1]}}, mul_rsp.q};
    end
    case (state)
      ST_DIFF: begin
        err <= diff_sat.value;
        acc <= '0;
      end
      ST_SUB: begin
        sub_val <= sub_sat.value;
        acc     <= '0;
      end
      default: ;
    endcase
    if (finish_fire) begin
      out_data.accel_command <= acc_sat.value;
      out_data.saturated     <= flag | acc_sat.clip;
    end
  end

endmodule

FILE: hw/rtl/colac_checker.sv
// Port-level checks for the angle controller, bound to the top level.
// Depends on colac_pkg and cascade_or_leadlag_angle_controller_unit.
module colac_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input colac_pkg::out_beat_t                out_data
);
  import colac_pkg::*;

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  a_reset_clean: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input taken while an item is in work");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !$rose(out_valid))
    else $error("result appeared without multiplier latency");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

endmodule

bind cascade_or_leadlag_angle_controller_unit colac_checker u_colac_checker (.*);
